// ===== hdl/pattern_set_occurrence_counter_defines.svh =====
// Assertion helpers for the pattern set occurrence counter checker.
// Each expects clk and rst_n in the scope where it is used.
`ifndef PATTERN_SET_OCCURRENCE_COUNTER_DEFINES_SVH
`define PATTERN_SET_OCCURRENCE_COUNTER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define PSOC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PSOC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/psoc_pkg.sv =====
`default_nettype none

package psoc_pkg;

  // Fixed field widths of the request and result channels and the pattern_count register
  localparam int OP_W   = 2;
  localparam int PI_W   = 10;
  localparam int POS_W  = 3;
  localparam int SYM_W  = 4;
  localparam int FC_W   = 11;
  localparam int CFG_W  = 11;

  // APB-style register port
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;
  localparam int REG_IDX_LSB = 2;

  typedef logic [OP_W-1:0]   op_t;
  typedef logic [PI_W-1:0]   idx_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [SYM_W-1:0]  sym_t;
  typedef logic [FC_W-1:0]   count_t;
  typedef logic [CFG_W-1:0]  cfg_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [DATA_W-1:0] data_t;
  typedef logic [ADDR_W-REG_IDX_LSB-1:0] reg_idx_t;

  localparam op_t OP_LOAD  = 2'd0;
  localparam op_t OP_START = 2'd1;
  localparam op_t OP_FEED  = 2'd2;

  localparam reg_idx_t REG_PATTERN_COUNT = 1'b0;

  localparam cfg_t PATTERN_COUNT_RESET = 11'd720;

endpackage

`default_nettype wire

// ===== hdl/psoc_in_if.sv =====
`default_nettype none

interface psoc_in_if;
  import psoc_pkg::*;

  logic valid;
  logic ready;
  op_t  operation;
  idx_t pattern_index;
  pos_t position;
  sym_t symbol;

  modport source (output valid, operation, pattern_index, position, symbol, input ready);
  modport sink   (input valid, operation, pattern_index, position, symbol, output ready);
endinterface

`default_nettype wire

// ===== hdl/psoc_out_if.sv =====
`default_nettype none

interface psoc_out_if;
  import psoc_pkg::*;

  logic   valid;
  logic   ready;
  count_t found_count;
  logic   all_found;

  modport source (output valid, found_count, all_found, input ready);
  modport sink   (input valid, found_count, all_found, output ready);
endinterface

`default_nettype wire

// ===== hdl/psoc_pattern_mem.sv =====
`default_nettype none

// Pattern table: one memory lane per symbol position, all lanes read at
// the same pattern address so a whole pattern row comes out at once.
module psoc_pattern_mem #(
  parameter int DEPTH    = 1024,
  parameter int LANES    = 6,
  parameter int SYM_BITS = 4
) (
  input  logic                              clk,
  input  logic [LANES-1:0]                  we,
  input  logic [$clog2(DEPTH)-1:0]          waddr,
  input  logic [SYM_BITS-1:0]               wdata,
  input  logic                              re,
  input  logic [$clog2(DEPTH)-1:0]          raddr,
  output logic [LANES-1:0][SYM_BITS-1:0]    rdata
);

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    logic [SYM_BITS-1:0] mem [DEPTH];
    logic [SYM_BITS-1:0] rd_r;

    always_ff @(posedge clk) begin
      if (we[k]) begin
        mem[waddr] <= wdata;
      end
      if (re) begin
        rd_r <= mem[raddr];
      end
    end

    assign rdata[k] = rd_r;
  end

endmodule

`default_nettype wire

// ===== hdl/psoc_ptr_mem.sv =====
`default_nettype none

// Per-pattern progress pointers, one write and one read port.
module psoc_ptr_mem #(
  parameter int DEPTH = 1024,
  parameter int PW    = 3
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [PW-1:0]            wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [PW-1:0]            rdata
);

  logic [PW-1:0] mem [DEPTH];
  logic [PW-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_r <= mem[raddr];
    end
  end

  assign rdata = rd_r;

endmodule

`default_nettype wire

// ===== hdl/psoc_step.sv =====
`default_nettype none

// Shared match unit: advances one pattern's pointer for one stream symbol.
module psoc_step #(
  parameter int LANES    = 6,
  parameter int SYM_BITS = 4,
  parameter int PW       = 3
) (
  input  logic [SYM_BITS-1:0]            sym,
  input  logic [PW-1:0]                  ptr,
  input  logic [LANES-1:0][SYM_BITS-1:0] row,
  output logic [PW-1:0]                  ptr_nxt,
  output logic                           hit
);

  localparam int LW = $clog2(LANES);

  logic          active;
  logic [LW-1:0] sel;
  logic [PW-1:0] ptr_inc;

  assign active  = ptr < PW'(LANES);
  assign sel     = active ? ptr[LW-1:0] : '0;
  assign ptr_inc = ptr + 1'b1;

  always_comb begin
    ptr_nxt = ptr;
    hit     = 1'b0;
    if (active) begin
      if (sym == row[sel]) begin
        ptr_nxt = ptr_inc;
        hit     = (ptr_inc == PW'(LANES));
      end else if (sym == row[0]) begin
        ptr_nxt = PW'(1);
      end else begin
        ptr_nxt = '0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/pattern_set_occurrence_counter.sv =====
// Channel   Dir  Handshake      Payload
// in_req    in   valid/ready    operation, pattern_index, position, symbol
// out_res   out  valid/ready    found_count, all_found
// apb       in   psel/penable   paddr, pwdata, prdata (pattern_count at 0x0)
//
// Load and unused-code requests go straight to the finish state.
// Feed request: scans the searched patterns, or finishes at once when every
// searched pattern is already found; the shared match unit handles one pattern
// per cycle, fed from the pattern and pointer memories.
// Start request: runs the pointer clearing sweep over all MAX_PATTERNS slots.
// After reset a clearing sweep over all MAX_PATTERNS slots runs before in_req.ready.
// A waiting result does not block the next request; one result is held at most.
`default_nettype none

module pattern_set_occurrence_counter #(
  parameter int PATTERN_LENGTH = 6,
  parameter int MAX_PATTERNS   = 1024,
  parameter int SYMBOL_BITS    = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  psoc_in_if.sink               in_req,
  psoc_out_if.source            out_res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [psoc_pkg::ADDR_W-1:0] paddr,
  input  logic [psoc_pkg::DATA_W-1:0] pwdata,
  output logic [psoc_pkg::DATA_W-1:0] prdata,
  output logic                  pready
);
  import psoc_pkg::*;

  localparam int LANES = PATTERN_LENGTH;
  localparam int IDX_W = $clog2(MAX_PATTERNS);
  localparam int CNT_W = $clog2(MAX_PATTERNS + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int PW    = $clog2(PATTERN_LENGTH + 1);
  localparam int SW    = (SYMBOL_BITS > SYM_W) ? SYMBOL_BITS : SYM_W;
  localparam int AW    = (IDX_W > PI_W) ? IDX_W : PI_W;

  // Sequencer states
  localparam logic [1:0] S_CLEAR  = 2'd0;
  localparam logic [1:0] S_IDLE   = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;        // scan issue / clear sweep index
  logic                   pend_r;                // read data for one pattern in flight
  logic [IDX_W-1:0]       pend_addr_r;
  logic [CNT_W-1:0]       total_r, total_nxt;    // patterns found this sequence
  logic                   clr_report_r, clr_report_nxt;
  logic [SYMBOL_BITS-1:0] sym_r, sym_nxt;
  cfg_t                   pcount_r;
  logic                   out_valid_r, out_valid_nxt;
  count_t                 out_count_r, out_count_nxt;
  logic                   out_all_r, out_all_nxt;

  // Effective search limit and completion flag
  logic [CMP_W-1:0] pc_ext, max_ext, limit_c, total_ext;
  logic [CNT_W-1:0] limit;
  logic             all_found_c;

  assign pc_ext      = CMP_W'(pcount_r);
  assign max_ext     = CMP_W'(MAX_PATTERNS);
  assign limit_c     = (pc_ext > max_ext) ? max_ext : pc_ext;
  assign limit       = limit_c[CNT_W-1:0];
  assign total_ext   = CMP_W'(total_r);
  assign all_found_c = total_ext >= limit_c;

  // Request decode
  logic                   accept;
  logic                   load_ok;
  logic [AW-1:0]          idx_wide;
  logic [SW-1:0]          sym_wide;
  logic [SYMBOL_BITS-1:0] sym_in;
  logic [LANES-1:0]       lane_we;

  assign in_req.ready = (state_r == S_IDLE);
  assign accept       = in_req.valid && in_req.ready;
  assign idx_wide     = AW'(in_req.pattern_index);
  assign sym_wide     = SW'(in_req.symbol);
  assign sym_in       = sym_wide[SYMBOL_BITS-1:0];
  assign load_ok      = accept && (in_req.operation == OP_LOAD)
                        && (32'(in_req.pattern_index) < 32'(MAX_PATTERNS))
                        && (32'(in_req.position) < 32'(PATTERN_LENGTH));

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      lane_we[k] = load_ok && (32'(in_req.position) == 32'(k));
    end
  end

  // Scan issue: one pattern address per cycle until the limit
  logic issuing;
  assign issuing = (state_r == S_SCAN) && (cnt_r != limit);

  logic [LANES-1:0][SYMBOL_BITS-1:0] row;
  logic [PW-1:0]                     ptr_rd, ptr_upd;
  logic                              hit;

  psoc_pattern_mem #(
    .DEPTH    (MAX_PATTERNS),
    .LANES    (LANES),
    .SYM_BITS (SYMBOL_BITS)
  ) u_pattern_mem (
    .clk   (clk),
    .we    (lane_we),
    .waddr (idx_wide[IDX_W-1:0]),
    .wdata (sym_in),
    .re    (issuing),
    .raddr (cnt_r[IDX_W-1:0]),
    .rdata (row)
  );

  // Pointer write port: clearing sweep or match-unit writeback
  logic             ptr_we;
  logic [IDX_W-1:0] ptr_waddr;
  logic [PW-1:0]    ptr_wdata;

  always_comb begin
    if (state_r == S_CLEAR) begin
      ptr_we    = 1'b1;
      ptr_waddr = cnt_r[IDX_W-1:0];
      ptr_wdata = '0;
    end else begin
      ptr_we    = pend_r;
      ptr_waddr = pend_addr_r;
      ptr_wdata = ptr_upd;
    end
  end

  psoc_ptr_mem #(
    .DEPTH (MAX_PATTERNS),
    .PW    (PW)
  ) u_ptr_mem (
    .clk   (clk),
    .we    (ptr_we),
    .waddr (ptr_waddr),
    .wdata (ptr_wdata),
    .re    (issuing),
    .raddr (cnt_r[IDX_W-1:0]),
    .rdata (ptr_rd)
  );

  psoc_step #(
    .LANES    (LANES),
    .SYM_BITS (SYMBOL_BITS),
    .PW       (PW)
  ) u_step (
    .sym     (sym_r),
    .ptr     (ptr_rd),
    .row     (row),
    .ptr_nxt (ptr_upd),
    .hit     (hit)
  );

  // Sequencer
  logic out_free;
  assign out_free = !out_valid_r || out_res.ready;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    total_nxt      = total_r;
    clr_report_nxt = clr_report_r;
    sym_nxt        = sym_r;
    out_valid_nxt  = out_valid_r && !out_res.ready;
    out_count_nxt  = out_count_r;
    out_all_nxt    = out_all_r;

    if (pend_r && hit) begin
      total_nxt = total_r + 1'b1;
    end

    unique case (state_r)
      S_CLEAR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MAX_PATTERNS - 1)) begin
          state_nxt = clr_report_r ? S_FINISH : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          unique case (in_req.operation)
            OP_START: begin
              total_nxt      = '0;
              cnt_nxt        = '0;
              clr_report_nxt = 1'b1;
              state_nxt      = S_CLEAR;
            end
            OP_FEED: begin
              sym_nxt   = sym_in;
              cnt_nxt   = '0;
              state_nxt = all_found_c ? S_FINISH : S_SCAN;
            end
            default: begin
              state_nxt = S_FINISH;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (issuing) begin
          cnt_nxt = cnt_r + 1'b1;
        end else if (!pend_r) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = total_ext[FC_W-1:0];
          out_all_nxt   = all_found_c;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      cnt_r        <= '0;
      pend_r       <= 1'b0;
      total_r      <= '0;
      clr_report_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      pend_r       <= issuing;
      total_r      <= total_nxt;
      clr_report_r <= clr_report_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= cnt_r[IDX_W-1:0];
    sym_r       <= sym_nxt;
    out_count_r <= out_count_nxt;
    out_all_r   <= out_all_nxt;
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.found_count = out_count_r;
  assign out_res.all_found   = out_all_r;

  // Register port
  reg_idx_t reg_idx;
  logic     cfg_we;

  assign reg_idx = paddr[ADDR_W-1:REG_IDX_LSB];
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && (reg_idx == REG_PATTERN_COUNT);
  assign prdata  = (reg_idx == REG_PATTERN_COUNT) ? DATA_W'(pcount_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcount_r <= PATTERN_COUNT_RESET;
    end else if (cfg_we) begin
      pcount_r <= pwdata[CFG_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/psoc_checker.sv =====
`default_nettype none

`include "pattern_set_occurrence_counter_defines.svh"

module psoc_checker (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          in_valid,
  input wire                          in_ready,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire [psoc_pkg::FC_W-1:0]     found_count,
  input wire                          all_found,
  input wire                          psel,
  input wire [psoc_pkg::ADDR_W-1:0]   paddr,
  input wire [psoc_pkg::DATA_W-1:0]   prdata
);
  import psoc_pkg::*;

  // Only one request is worked on at a time.
  `PSOC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")

  // A result appears only after the sequencer has left idle.
  `PSOC_ASSERT_SAME(a_result_from_busy, $rose(out_valid), !$past(in_ready), "result from idle")

  // A stalled result holds.
  `PSOC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(found_count) && $stable(all_found), "stalled result changed")

  // Unmapped register space reads as zero.
  `PSOC_ASSERT_SAME(a_prdata_unmapped, psel && (paddr[ADDR_W-1:REG_IDX_LSB] != REG_PATTERN_COUNT),
    prdata == '0, "unmapped read not zero")

endmodule

bind pattern_set_occurrence_counter psoc_checker u_psoc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_req.valid),
  .in_ready    (in_req.ready),
  .out_valid   (out_res.valid),
  .out_ready   (out_res.ready),
  .found_count (out_res.found_count),
  .all_found   (out_res.all_found),
  .psel        (psel),
  .paddr       (paddr),
  .prdata      (prdata)
);

`default_nettype wire

// ===== tb/pattern_set_occurrence_counter_tb.sv =====
// Testbench for the pattern set occurrence counter.
// Requests go in through a queue-fed driver. A monitor predicts every
// result at the moment its request is accepted, and checks each result
// against the oldest prediction that is still waiting.
module pattern_set_occurrence_counter_tb;
  import psoc_pkg::*;

  localparam int  PLEN = 6;             // symbols per pattern
  localparam int  MAXP = 1024;          // pattern slots in the block
  localparam int  FILL_PATS = 32;       // patterns fully loaded; search never goes past
  localparam op_t OP_SPARE = 2'd3;      // unused code, must change nothing

  localparam int HOLD_CYCLES  = 600;    // long receiver hold-off
  localparam int DRAIN_CYCLES = 1100;   // outlasts a start request's clearing sweep
  localparam int STALL_LIMIT  = 20000;  // cycles without any handshake

  // Directed patterns, symbol 0 in the low nibble.
  // Distinct symbols spanning both extremes of the symbol range.
  localparam logic [PLEN*SYM_W-1:0] SPREAD_PAT = 24'h96C3F0;
  // Long run of one symbol: exposes the simple restart (no overlap reuse).
  localparam logic [PLEN*SYM_W-1:0] REPEAT_PAT = 24'h955555;

  typedef struct packed {
    op_t  op;
    idx_t idx;
    pos_t pos;
    sym_t sym;
  } req_t;

  typedef struct packed {
    count_t found;
    logic   complete;
  } tally_t;

  bit    clk;
  logic  rst_n   = 1'b0;
  logic  psel    = 1'b0;
  logic  penable = 1'b0;
  logic  pwrite  = 1'b0;
  addr_t paddr   = '0;
  data_t pwdata  = '0;
  data_t prdata;
  logic  pready;

  psoc_in_if  req_bus ();
  psoc_out_if res_bus ();

  pattern_set_occurrence_counter #(
    .PATTERN_LENGTH(PLEN),
    .MAX_PATTERNS  (MAXP),
    .SYMBOL_BITS   (SYM_W)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_bus),
    .out_res(res_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predicted block state: pattern table, per-pattern progress, match count,
  // and the pattern_count register as last written.
  sym_t        pat_mem [MAXP][PLEN];
  logic [2:0]  progress [MAXP];
  int unsigned hits = 0;
  int unsigned search_cfg = PATTERN_COUNT_RESET;

  // Pattern table as the stimulus planner sees it: updated when a load is
  // queued, so feeds built from it match what the block will hold by then.
  sym_t plan_mem [MAXP][PLEN];

  req_t   pending_reqs [$];
  tally_t expected_tallies [$];

  int unsigned reqs_queued   = 0;
  int unsigned reqs_accepted = 0;
  int unsigned results_seen  = 0;
  int unsigned mismatches    = 0;
  int unsigned quiet_cycles  = 0;
  logic        timed_out     = 1'b0;
  logic        req_taken     = 1'b0;

  // Idle rates in percent; changed only while the block is drained.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // Receiver hold-off: stimulus bumps stall_orders, receiver serves it.
  int unsigned stall_orders = 0;
  int unsigned stall_served = 0;
  int unsigned hold_left    = 0;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch at result %0d: %s got %0d want %0d", results_seen, what, got, want);
    mismatches++;
  endtask

  // Patterns actually searched: the register value capped at the table size.
  function automatic int unsigned eff_limit();
    return (search_cfg > MAXP) ? MAXP : search_cfg;
  endfunction

  // Applies one request to the predicted state and returns the result it
  // should produce. Every request yields exactly one result.
  function automatic tally_t tally_after(input req_t r);
    int unsigned lim;
    int unsigned ptr;
    tally_t      t;
    lim = eff_limit();
    case (r.op)
      OP_LOAD: begin
        // positions past the pattern end are dropped
        if (r.pos < PLEN) pat_mem[r.idx][r.pos] = r.sym;
      end
      OP_START: begin
        foreach (progress[k]) progress[k] = '0;
        hits = 0;
      end
      OP_FEED: begin
        // once every searched pattern is found, feeds are ignored
        if (hits < lim) begin
          for (int j = 0; j < lim; j++) begin
            ptr = progress[j];
            if (ptr < PLEN) begin
              if (r.sym == pat_mem[j][ptr]) begin
                ptr++;
                if (ptr == PLEN) hits++;
              end else if (r.sym == pat_mem[j][0]) begin
                ptr = 1;
              end else begin
                ptr = 0;
              end
              progress[j] = ptr[2:0];
            end
          end
        end
      end
      default: ;
    endcase
    t.found    = count_t'(hits);
    t.complete = (hits >= lim);
    return t;
  endfunction

  function automatic void push_req(input op_t op, input idx_t idx, input pos_t pos,
                                   input sym_t sym);
    req_t r;
    r.op  = op;
    r.idx = idx;
    r.pos = pos;
    r.sym = sym;
    pending_reqs.push_back(r);
    if (op == OP_LOAD && pos < PLEN) plan_mem[idx][pos] = sym;
    reqs_queued++;
  endfunction

  // Feed requests carry junk in the fields they do not use.
  function automatic void push_feed(input sym_t sym);
    push_req(OP_FEED, idx_t'($urandom), pos_t'($urandom), sym);
  endfunction

  // Block until every queued request is accepted and every result checked.
  task automatic wait_idle();
    do @(negedge clk);
    while (reqs_accepted != reqs_queued || expected_tallies.size() != 0);
    @(posedge clk);
  endtask

  // Register write followed by a readback, both on the APB-style port.
  // Only called while the block is drained.
  task automatic set_search_limit(input cfg_t value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr_t'(REG_PATTERN_COUNT) << REG_IDX_LSB;
    pwdata  <= data_t'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    search_cfg = value;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    if (prdata[CFG_W-1:0] !== value)
      report_mismatch("pattern_count readback", prdata[CFG_W-1:0], value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Random traffic, mostly well-formed: whole searched patterns, sometimes
  // preceded by a broken prefix, mixed with noise symbols, restarts, loads
  // that rewrite patterns mid-sequence, and spare-code requests.
  task automatic gen_traffic(input int unsigned n_items);
    int unsigned lim;
    int unsigned stop_at;
    int unsigned pick;
    int unsigned j;
    int unsigned cut;
    lim     = eff_limit();
    stop_at = reqs_queued + n_items;
    while (reqs_queued < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 60 && lim != 0) begin
        j = $urandom_range(0, lim - 1);
        if ($urandom_range(0, 3) == 0) begin
          cut = $urandom_range(1, PLEN - 1);
          for (int k = 0; k < cut; k++) push_feed(plan_mem[j][k]);
          push_feed(sym_t'($urandom));
        end
        for (int k = 0; k < PLEN; k++) push_feed(plan_mem[j][k]);
      end else if (pick < 75) begin
        repeat ($urandom_range(1, 4)) push_feed(sym_t'($urandom));
      end else if (pick < 82) begin
        push_req(OP_START, idx_t'($urandom), pos_t'($urandom), sym_t'($urandom));
      end else if (pick < 95) begin
        if (lim != 0 && $urandom_range(0, 1) == 1) j = $urandom_range(0, lim - 1);
        else j = $urandom_range(0, MAXP - 1);
        push_req(OP_LOAD, idx_t'(j), pos_t'($urandom_range(0, 7)), sym_t'($urandom));
      end else begin
        push_req(OP_SPARE, idx_t'($urandom), pos_t'($urandom), sym_t'($urandom));
      end
    end
  endtask

  task automatic run_stimulus();
    sym_t s;
    send_idle_pct = 25;
    recv_idle_pct = 49;
    repeat (12) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    set_search_limit(PATTERN_COUNT_RESET);
    // Nothing loaded yet: only requests that read no pattern.
    // Spare code and loads past the pattern end must leave the state alone.
    push_req(OP_SPARE, '1, '1, '1);
    push_req(OP_START, '0, '0, '0);
    push_req(OP_LOAD, '1, pos_t'(PLEN), '1);
    push_req(OP_LOAD, '1, '1, '0);
    wait_idle();

    // Zero patterns searched: all_found reads 1 and feeds do nothing.
    set_search_limit('0);
    push_feed('1);
    push_feed('0);
    push_req(OP_SPARE, '0, '0, '0);

    // Fill every pattern that a later pattern_count searches.
    // Every fourth pattern draws from a narrow alphabet so noise hits it too.
    for (int j = 0; j < FILL_PATS; j++) begin
      for (int k = 0; k < PLEN; k++) begin
        if (j == 0) s = SPREAD_PAT[k*SYM_W +: SYM_W];
        else if (j == 1) s = REPEAT_PAT[k*SYM_W +: SYM_W];
        else if (j % 4 == 0) s = sym_t'($urandom_range(0, 3));
        else s = sym_t'($urandom);
        push_req(OP_LOAD, idx_t'(j), pos_t'(k), s);
      end
    end
    wait_idle();

    // Two patterns: find the spread one.
    set_search_limit(2);
    push_req(OP_START, '0, '0, '0);
    for (int k = 0; k < PLEN; k++) push_feed(SPREAD_PAT[k*SYM_W +: SYM_W]);
    wait_idle();

    // Count lowered to the found count mid-sequence: feeds ignored.
    set_search_limit(1);
    push_feed(REPEAT_PAT[SYM_W-1:0]);
    wait_idle();

    // Back to two: six repeats then the tail miss because a mismatch only
    // falls back to the first symbol; after a clean restart the run matches,
    // and the feed after that is ignored since all are found.
    set_search_limit(2);
    repeat (PLEN) push_feed(REPEAT_PAT[SYM_W-1:0]);
    push_feed(REPEAT_PAT[PLEN*SYM_W-1 -: SYM_W]);
    for (int k = 0; k < PLEN; k++) push_feed(REPEAT_PAT[k*SYM_W +: SYM_W]);
    push_feed('0);
    wait_idle();

    // Random phases, first with sender 25% / receiver 49% idle.
    set_search_limit(1);
    gen_traffic(40);
    wait_idle();

    // Receiver holds off long enough for the block to back up its input.
    set_search_limit(5);
    gen_traffic(90);
    stall_orders++;
    wait_idle();

    send_idle_pct = 49;
    recv_idle_pct = 25;
    set_search_limit(cfg_t'(FILL_PATS));
    gen_traffic(25);
    wait_idle();

    // Sender pauses halfway until every result is back.
    set_search_limit(12);
    gen_traffic(45);
    wait_idle();
    gen_traffic(45);
    wait_idle();

    // No idling from here on.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_search_limit(cfg_t'(FILL_PATS - 1));
    gen_traffic(15);
    wait_idle();

    set_search_limit(7);
    gen_traffic(15);
    wait_idle();

    set_search_limit(3);
    gen_traffic(80);
    wait_idle();

    // Let any stray result show up before closing.
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Request driver: a request stays offered until it is taken.
  always @(negedge clk) begin : drive_requests
    req_t r;
    if (!rst_n) begin
      req_bus.valid <= 1'b0;
    end else if (!req_bus.valid || req_taken) begin
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        r = pending_reqs.pop_front();
        req_bus.valid         <= 1'b1;
        req_bus.operation     <= r.op;
        req_bus.pattern_index <= r.idx;
        req_bus.position      <= r.pos;
        req_bus.symbol        <= r.sym;
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random back-pressure plus the ordered long hold-off.
  always @(negedge clk) begin : drive_result_ready
    if (!rst_n) begin
      res_bus.ready <= 1'b0;
    end else if (stall_served != stall_orders) begin
      stall_served = stall_orders;
      hold_left    = HOLD_CYCLES;
      res_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor: checks results against predictions, predicts each accepted
  // request, and counts cycles without any handshake.
  always @(posedge clk) begin : watch_channels
    req_t   seen;
    tally_t want;
    req_taken <= req_bus.valid && req_bus.ready;
    if (rst_n && ((req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready)))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;

    // results first: a result never belongs to a request taken on the same edge
    if (rst_n && res_bus.valid && res_bus.ready) begin
      results_seen++;
      if (expected_tallies.size() == 0) begin
        report_mismatch("result with no request pending", res_bus.found_count, 0);
      end else begin
        want = expected_tallies.pop_front();
        if (res_bus.found_count !== want.found)
          report_mismatch("found_count", res_bus.found_count, want.found);
        if (res_bus.all_found !== want.complete)
          report_mismatch("all_found", res_bus.all_found, want.complete);
      end
    end

    if (rst_n && req_bus.valid && req_bus.ready) begin
      seen.op  = req_bus.operation;
      seen.idx = req_bus.pattern_index;
      seen.pos = req_bus.position;
      seen.sym = req_bus.symbol;
      expected_tallies.push_back(tally_after(seen));
      reqs_accepted++;
    end
  end

  initial begin : main
    req_bus.valid         = 1'b0;
    req_bus.operation     = OP_LOAD;
    req_bus.pattern_index = '0;
    req_bus.position      = '0;
    req_bus.symbol        = '0;
    res_bus.ready         = 1'b0;
    fork
      run_stimulus();
      begin
        while (quiet_cycles < STALL_LIMIT) @(negedge clk);
        timed_out = 1'b1;
      end
    join_any
    if (expected_tallies.size() != 0)
      report_mismatch("results never delivered", expected_tallies.size(), 0);
    if (!timed_out && mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
